// ===== hdl/crc8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fr_pkg: shared definitions for the CRC-8 frame receiver
// Frame constants, parse phases, status codes, the front-to-back command
// format and the byte-wise CRC-8 update (reflected polynomial 0x8C).
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

	// Frame constants
	localparam logic [7:0] CRC_POLY    = 8'h8C;
	localparam logic [7:0] HDR_FIRST   = 8'h55;
	localparam logic [7:0] HDR_SECOND  = 8'hAA;
	localparam logic [7:0] TRAIL_CR    = 8'h0D;
	localparam logic [7:0] TRAIL_LF    = 8'h0A;
	localparam int         PAYLOAD_LEN = 12;
	localparam int         IDX_W       = 4;

	// Default depth of the command queue between front and back
	localparam int CMD_DEPTH = 4;

	// Parser phases
	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_LEN,
		PH_PAY,
		PH_CRC,
		PH_SKIP
	} phase_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK,
		ST_HDR,
		ST_SUM,
		ST_LEN
	} status_t;

	// Command kinds issued by the front
	typedef enum logic {
		CMD_STORE,
		CMD_EMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t          op;
		status_t          status;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	// One byte of reflected CRC-8, eight shift steps
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/crc8_frame_receiver_unit.sv =====
// Result path: the command for the CRC byte, or the bad header or length byte,
//   passes through the command queue into the result register (empty low).
// Throughput: one byte per cycle while full is low; the parser and CRC update
//   take a byte each cycle, and the command queue absorbs result-port stalls.
// Reset: asynchronous, active low; parser waits for the first header byte, and
//   the command queue and result slot are emptied. Frame store is not cleared.
// ----------------------------------------------------------------------------
// crc8_frame_receiver_unit: serial frame receiver with CRC-8 check
// Front parser classifies bytes into commands, a short queue decouples it
// from the back end that assembles and holds the results.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_frame_receiver_unit #(
	parameter int CMD_DEPTH = crc8fr_pkg::CMD_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [7:0]  rx_byte,
	output logic             full,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       status,
	output logic [31:0]      x_bits,
	output logic [31:0]      y_bits,
	output logic [31:0]      theta_bits
);

	logic              cmd_push;
	logic              cmd_pop;
	logic              cmd_empty;
	crc8fr_pkg::cmd_t  cmd_in;
	crc8fr_pkg::cmd_t  cmd_out;

	// Byte parser
	crc8fr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rx_byte  (rx_byte),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Command queue
	crc8fr_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	// Executor and result register
	crc8fr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd_out),
		.cmd_pop    (cmd_pop),
		.pop        (pop),
		.empty      (empty),
		.status     (status),
		.x_bits     (x_bits),
		.y_bits     (y_bits),
		.theta_bits (theta_bits)
	);

endmodule

`default_nettype wire

// ===== hdl/crc8fr_front.sv =====
// ----------------------------------------------------------------------------
// crc8fr_front: byte parser
// Tracks the frame phase and running CRC, classifies each accepted byte and
// issues at most one command per byte: store a payload byte or emit a result.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [7:0]        rx_byte,
	input  wire logic              full,
	output logic                   cmd_push,
	output crc8fr_pkg::cmd_t       cmd
);

	crc8fr_pkg::phase_t                 phase_q, phase_d;
	logic [7:0]                         crc_q, crc_d;
	logic [crc8fr_pkg::IDX_W-1:0]       idx_q, idx_d;
	logic                               last_cr_q, last_cr_d;
	logic                               accept;
	logic [7:0]                         crc_upd;
	logic                               want_push;

	assign accept = push && !full;

	// CRC restarts from zero on the first header byte
	assign crc_upd = crc8fr_pkg::crc8_update(
		(phase_q == crc8fr_pkg::PH_HDR0) ? 8'h00 : crc_q, rx_byte);

	// Next state
	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		idx_d     = idx_q;
		last_cr_d = last_cr_q;
		if (accept) begin
			case (phase_q)
				crc8fr_pkg::PH_HDR0: begin
					if (rx_byte == crc8fr_pkg::HDR_FIRST) begin
						crc_d   = crc_upd;
						phase_d = crc8fr_pkg::PH_HDR1;
					end else begin
						phase_d   = crc8fr_pkg::PH_SKIP;
						last_cr_d = (rx_byte == crc8fr_pkg::TRAIL_CR);
					end
				end
				crc8fr_pkg::PH_HDR1: begin
					if (rx_byte == crc8fr_pkg::HDR_SECOND) begin
						crc_d   = crc_upd;
						phase_d = crc8fr_pkg::PH_LEN;
					end else begin
						phase_d   = crc8fr_pkg::PH_SKIP;
						last_cr_d = (rx_byte == crc8fr_pkg::TRAIL_CR);
					end
				end
				crc8fr_pkg::PH_LEN: begin
					if (rx_byte == 8'(crc8fr_pkg::PAYLOAD_LEN)) begin
						crc_d   = crc_upd;
						idx_d   = '0;
						phase_d = crc8fr_pkg::PH_PAY;
					end else begin
						phase_d   = crc8fr_pkg::PH_SKIP;
						last_cr_d = (rx_byte == crc8fr_pkg::TRAIL_CR);
					end
				end
				crc8fr_pkg::PH_PAY: begin
					crc_d = crc_upd;
					idx_d = idx_q + 1'b1;
					if (idx_q == crc8fr_pkg::IDX_W'(crc8fr_pkg::PAYLOAD_LEN - 1)) begin
						phase_d = crc8fr_pkg::PH_CRC;
					end
				end
				crc8fr_pkg::PH_CRC: begin
					phase_d   = crc8fr_pkg::PH_SKIP;
					last_cr_d = 1'b0;
				end
				default: begin
					// skipping until CR directly followed by LF
					if (last_cr_q && rx_byte == crc8fr_pkg::TRAIL_LF) begin
						phase_d   = crc8fr_pkg::PH_HDR0;
						last_cr_d = 1'b0;
					end else begin
						phase_d   = crc8fr_pkg::PH_SKIP;
						last_cr_d = (rx_byte == crc8fr_pkg::TRAIL_CR);
					end
				end
			endcase
		end
	end

	// Command outputs
	always_comb begin
		want_push  = 1'b0;
		cmd.op     = crc8fr_pkg::CMD_EMIT;
		cmd.status = crc8fr_pkg::ST_OK;
		cmd.data   = rx_byte;
		cmd.idx    = idx_q;
		case (phase_q)
			crc8fr_pkg::PH_HDR0: begin
				want_push  = (rx_byte != crc8fr_pkg::HDR_FIRST);
				cmd.status = crc8fr_pkg::ST_HDR;
			end
			crc8fr_pkg::PH_HDR1: begin
				want_push  = (rx_byte != crc8fr_pkg::HDR_SECOND);
				cmd.status = crc8fr_pkg::ST_HDR;
			end
			crc8fr_pkg::PH_LEN: begin
				want_push  = (rx_byte != 8'(crc8fr_pkg::PAYLOAD_LEN));
				cmd.status = crc8fr_pkg::ST_LEN;
			end
			crc8fr_pkg::PH_PAY: begin
				want_push = 1'b1;
				cmd.op    = crc8fr_pkg::CMD_STORE;
			end
			crc8fr_pkg::PH_CRC: begin
				want_push  = 1'b1;
				cmd.status = (rx_byte == crc_q) ? crc8fr_pkg::ST_OK : crc8fr_pkg::ST_SUM;
			end
			default: begin
				want_push = 1'b0;
			end
		endcase
	end

	assign cmd_push = accept && want_push;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crc8fr_pkg::PH_HDR0;
			crc_q     <= '0;
			idx_q     <= '0;
			last_cr_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			crc_q     <= crc_d;
			idx_q     <= idx_d;
			last_cr_q <= last_cr_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crc8fr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// crc8fr_cmd_fifo: command queue between front and back
// Small register FIFO; lets the parser keep taking bytes while the back end
// waits on the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_cmd_fifo #(
	parameter int DEPTH = crc8fr_pkg::CMD_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire crc8fr_pkg::cmd_t  wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output crc8fr_pkg::cmd_t       rd_data,
	output logic                   empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	crc8fr_pkg::cmd_t  mem_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/crc8fr_back.sv =====
// ----------------------------------------------------------------------------
// crc8fr_back: command executor and result register
// Writes payload bytes into the frame store and, on an emit command, loads
// the status and three little-endian words into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_empty,
	input  wire crc8fr_pkg::cmd_t  cmd,
	output logic                   cmd_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [1:0]             status,
	output logic [31:0]            x_bits,
	output logic [31:0]            y_bits,
	output logic [31:0]            theta_bits
);

	logic [7:0]           payload_q [crc8fr_pkg::PAYLOAD_LEN];
	logic                 out_valid_q;
	crc8fr_pkg::status_t  status_q;
	logic [31:0]          x_q, y_q, theta_q;
	logic                 slot_free;
	logic                 do_store, do_emit;
	logic                 frame_ok;

	// Result slot frees up when empty or when its transaction completes
	assign slot_free = !out_valid_q || pop;
	assign cmd_pop   = !cmd_empty && (cmd.op == crc8fr_pkg::CMD_STORE || slot_free);
	assign do_store  = cmd_pop && (cmd.op == crc8fr_pkg::CMD_STORE);
	assign do_emit   = cmd_pop && (cmd.op == crc8fr_pkg::CMD_EMIT);
	assign frame_ok  = (cmd.status == crc8fr_pkg::ST_OK);

	// Frame store
	always_ff @(posedge clk) begin
		for (int i = 0; i < crc8fr_pkg::PAYLOAD_LEN; i++) begin
			if (do_store && cmd.idx == crc8fr_pkg::IDX_W'(i)) begin
				payload_q[i] <= cmd.data;
			end
		end
	end

	// Result payload; words are zero on any error
	always_ff @(posedge clk) begin
		if (do_emit) begin
			status_q <= cmd.status;
			x_q      <= frame_ok ? {payload_q[3], payload_q[2], payload_q[1], payload_q[0]}
			                     : 32'h0;
			y_q      <= frame_ok ? {payload_q[7], payload_q[6], payload_q[5], payload_q[4]}
			                     : 32'h0;
			theta_q  <= frame_ok ? {payload_q[11], payload_q[10], payload_q[9], payload_q[8]}
			                     : 32'h0;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign status     = status_q;
	assign x_bits     = x_q;
	assign y_bits     = y_q;
	assign theta_bits = theta_q;

endmodule

`default_nettype wire
